FILE: rtl/pkgst_pkg.sv
// Package for the per-key gap severity tracker.
// Holds widths, register indexes, reset values, codes and the shared types.
// No dependencies.
`default_nettype none

package pkgst_pkg;

    localparam int KEY_COUNT = 256;
    localparam int KEY_AW    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    localparam int KEY_W    = 8;
    localparam int TIME_W   = 64;
    localparam int THR_W    = 32;
    localparam int STREAK_W = 8;
    localparam int SEV_W    = 2;
    localparam int EVT_W    = 3;

    // Stream packing.
    localparam int IN_USED_W   = KEY_W + 2 * TIME_W;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_USED_W  = 2 * SEV_W + TIME_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = EVT_W;

    // Configuration port.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = THR_W;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALERT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAK   = 3'd4;

    localparam logic [THR_W-1:0]    WARN_RST     = 32'd100;
    localparam logic [THR_W-1:0]    ALERT_RST    = 32'd500;
    localparam logic [THR_W-1:0]    CRITICAL_RST = 32'd2000;
    localparam logic [THR_W-1:0]    COOLDOWN_RST = 32'd5000;
    localparam logic [STREAK_W-1:0] STREAK_RST   = 8'd3;

    localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

    localparam logic [SEV_W-1:0] SEV_NONE     = 2'd0;
    localparam logic [SEV_W-1:0] SEV_WARN     = 2'd1;
    localparam logic [SEV_W-1:0] SEV_ALERT    = 2'd2;
    localparam logic [SEV_W-1:0] SEV_CRITICAL = 2'd3;

    typedef enum logic [EVT_W-1:0] {
        EV_IGNORED    = 3'd0,
        EV_UNCHANGED  = 3'd1,
        EV_RECOVERED  = 3'd2,
        EV_ESCALATED  = 3'd3,
        EV_DOWNGRADED = 3'd4
    } t_event;

    typedef struct packed {
        logic [THR_W-1:0]    warn;
        logic [THR_W-1:0]    alert;
        logic [THR_W-1:0]    critical;
        logic [THR_W-1:0]    cooldown;
        logic [STREAK_W-1:0] streak_needed;
    } t_cfg;

    // One stored entry per key.
    typedef struct packed {
        logic [TIME_W-1:0]   last_change;
        logic [STREAK_W-1:0] streak;
        logic [SEV_W-1:0]    severity;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Item as it sits in the update stage.
    typedef struct packed {
        logic              ignore;
        logic              in_range;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] now;
    } t_item;

    typedef struct packed {
        t_event            event_kind;
        logic [SEV_W-1:0]  held;
        logic [SEV_W-1:0]  seen;
        logic [TIME_W-1:0] gap;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/pkgst_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Read-during-write to the same address returns the old contents. No dependencies.
`default_nettype none

module pkgst_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pkgst_update.sv
// Severity update for one item: classifies the gap and works out the new entry.
// Depends on pkgst_pkg.
`default_nettype none

module pkgst_update
    import pkgst_pkg::*;
(
    input  wire t_cfg    i_cfg,
    input  wire t_item   i_item,
    input  wire t_entry  i_cur,
    output t_entry       o_next,
    output logic         o_wr,
    output t_result      o_res
);

    logic [TIME_W-1:0]   elapsed;
    logic                cooled;
    logic [SEV_W-1:0]    seen;
    logic [SEV_W-1:0]    held;
    logic [STREAK_W-1:0] streak_inc;

    always_comb begin
        elapsed = i_item.now - i_cur.last_change;
        cooled  = elapsed >= TIME_W'(i_cfg.cooldown);

        // Critical is tested first, whatever order the thresholds are in.
        if (i_item.gap >= TIME_W'(i_cfg.critical)) begin
            seen = SEV_CRITICAL;
        end else if (i_item.gap >= TIME_W'(i_cfg.alert)) begin
            seen = SEV_ALERT;
        end else if (i_item.gap >= TIME_W'(i_cfg.warn)) begin
            seen = SEV_WARN;
        end else begin
            seen = SEV_NONE;
        end

        streak_inc = (i_cur.streak == STREAK_MAX) ? i_cur.streak
                                                  : i_cur.streak + STREAK_W'(1);

        held             = i_cur.severity;
        o_next           = i_cur;
        o_wr             = 1'b0;
        o_res.event_kind = EV_UNCHANGED;
        o_res.seen       = seen;
        o_res.gap        = i_item.gap;

        if (i_item.ignore) begin
            o_res.event_kind = EV_IGNORED;
            o_res.seen       = SEV_NONE;
            o_res.gap        = '0;
            if (!i_item.in_range) begin
                held = SEV_NONE;
            end
        end else begin
            o_wr = 1'b1;
            if (seen == SEV_NONE) begin
                // Recovery is immediate and leaves the change time alone.
                if (held != SEV_NONE) begin
                    held             = SEV_NONE;
                    o_res.event_kind = EV_RECOVERED;
                end
                o_next.streak = '0;
            end else if (seen > held) begin
                if (cooled) begin
                    held               = seen;
                    o_next.last_change = i_item.now;
                    o_res.event_kind   = EV_ESCALATED;
                end
                o_next.streak = '0;
            end else begin
                o_next.streak = streak_inc;
                if (seen < held && streak_inc >= i_cfg.streak_needed && cooled) begin
                    held               = seen;
                    o_next.last_change = i_item.now;
                    o_next.streak      = '0;
                    o_res.event_kind   = EV_DOWNGRADED;
                end
            end
        end

        o_next.severity = held;
        o_res.held      = held;
    end

endmodule

`default_nettype wire

FILE: rtl/per_key_gap_severity_tracker.sv
// Top level of the per-key gap severity tracker: stream ports, pipeline, forwarding.
// Depends on pkgst_pkg, pkgst_ram and pkgst_update.
`default_nettype none

// Channel  Direction  Handshake                    Payload
// -------  ---------  ---------------------------  -----------------------------------
// s_axis   in         i_s_axis_tvalid/o_..tready   key, previous and current time
// m_axis   out        o_m_axis_tvalid/i_..tready   event kind, severities, gap
// cfg      in         i_cfg_we                     register index and write data
//
// One item is accepted every cycle while the update stage is empty or moving on. The
// item is registered into the update stage, and its result into the output register
// when that stage moves on. The rate is set by the per-key state memory, which is read
// when an item is accepted and written back when the update stage moves on; a one-entry
// forwarding register covers a read that overlaps the write of the same key. After
// reset a clearing pass writes one memory entry per cycle, so the input is not ready
// until all KEY_COUNT (256) entries are cleared. When the output is stalled the update
// stage holds, and the input stays ready only while that stage can move on.

module per_key_gap_severity_tracker
    import pkgst_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // Fields from bit 0: key_index[7:0], previous_time_ms[71:8],
    // current_time_ms[135:72].
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Fields from bit 0: key_present[0].
    input  wire logic [IN_TUSER_W-1:0]  i_s_axis_tuser,

    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // Fields from bit 0: held_severity[1:0], seen_severity[3:2], gap_ms[67:4],
    // zero fill above.
    output logic      [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // Fields from bit 0: event_kind[2:0].
    output logic      [OUT_TUSER_W-1:0] o_m_axis_tuser,

    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire logic [CFG_DAT_W-1:0]   i_cfg_wdata
);

    // Configuration registers, to be written by the user only while the block is idle; the block does not enforce it.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warn          <= WARN_RST;
            r_cfg.alert         <= ALERT_RST;
            r_cfg.critical      <= CRITICAL_RST;
            r_cfg.cooldown      <= COOLDOWN_RST;
            r_cfg.streak_needed <= STREAK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WARN:     r_cfg.warn          <= i_cfg_wdata;
                CFG_ALERT:    r_cfg.alert         <= i_cfg_wdata;
                CFG_CRITICAL: r_cfg.critical      <= i_cfg_wdata;
                CFG_COOLDOWN: r_cfg.cooldown      <= i_cfg_wdata;
                CFG_STREAK:   r_cfg.streak_needed <= i_cfg_wdata[STREAK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input fields.
    logic [KEY_W-1:0]  in_key;
    logic              in_present;
    logic [TIME_W-1:0] in_prev;
    logic [TIME_W-1:0] in_now;
    logic [31:0]       in_key_ext;
    logic [KEY_AW-1:0] in_addr;
    logic              in_range;
    logic              in_ignore;
    logic [TIME_W-1:0] in_gap;
    logic              in_accept;

    assign in_key     = i_s_axis_tdata[KEY_W-1:0];
    assign in_prev    = i_s_axis_tdata[KEY_W +: TIME_W];
    assign in_now     = i_s_axis_tdata[KEY_W + TIME_W +: TIME_W];
    assign in_present = i_s_axis_tuser[0];
    assign in_key_ext = 32'(in_key);
    assign in_addr    = in_key_ext[KEY_AW-1:0];
    assign in_range   = in_key_ext < 32'(KEY_COUNT);
    // An item without a key, without an earlier arrival or with a key past the
    // table is passed through without touching any state.
    assign in_ignore  = !in_present || (in_prev == '0) || !in_range;
    assign in_gap     = (in_now > in_prev) ? (in_now - in_prev) : '0;

    // Clearing pass after reset: one memory entry is zeroed per cycle.
    logic              r_clr_busy;
    logic [KEY_AW-1:0] r_clr_addr;
    logic              clr_last;

    assign clr_last = (r_clr_addr == KEY_AW'(KEY_COUNT - 1));

    // Update stage and output register handshake.
    logic r_s1_valid;
    logic r_m_valid;
    logic s1_adv;

    assign s1_adv          = r_s1_valid && (!r_m_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    t_item             r_s1_item;
    logic [KEY_AW-1:0] r_s1_addr;

    // Last write back, forwarded to a read that raced it.
    logic              r_fwd_vld;
    logic [KEY_AW-1:0] r_fwd_addr;
    t_entry            r_fwd_entry;

    t_entry            ram_q;
    t_entry            cur_entry;
    t_entry            upd_next;
    logic              upd_wr;
    t_result           upd_res;
    logic              item_we;
    logic              ram_we;
    logic [KEY_AW-1:0] ram_waddr;
    t_entry            ram_wdata;

    assign item_we   = s1_adv && upd_wr;
    assign ram_we    = r_clr_busy || item_we;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign ram_wdata = r_clr_busy ? t_entry'('0) : upd_next;

    pkgst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (KEY_COUNT)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept && in_range),
        .i_raddr (in_addr),
        .o_rdata (ram_q)
    );

    // The forwarding register always holds the newest write, so a key match
    // there wins over the memory.
    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_s1_addr)) begin
            cur_entry = r_fwd_entry;
        end else begin
            cur_entry = ram_q;
        end
    end

    pkgst_update u_update (
        .i_cfg  (r_cfg),
        .i_item (r_s1_item),
        .i_cur  (cur_entry),
        .o_next (upd_next),
        .o_wr   (upd_wr),
        .o_res  (upd_res)
    );

    logic n_s1_valid;
    logic n_m_valid;

    assign n_s1_valid = in_accept || (r_s1_valid && !s1_adv);
    assign n_m_valid  = s1_adv || (r_m_valid && !i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_m_valid  <= 1'b0;
            r_fwd_vld  <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_m_valid  <= n_m_valid;
            if (item_we) begin
                r_fwd_vld <= 1'b1;
            end
            if (r_clr_busy) begin
                if (clr_last) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + KEY_AW'(1);
            end
        end
    end

    // Payload registers.
    t_result r_m_res;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item.ignore   <= in_ignore;
            r_s1_item.in_range <= in_range;
            r_s1_item.gap      <= in_gap;
            r_s1_item.now      <= in_now;
            r_s1_addr          <= in_addr;
        end
        if (item_we) begin
            r_fwd_addr  <= r_s1_addr;
            r_fwd_entry <= upd_next;
        end
        if (s1_adv) begin
            r_m_res <= upd_res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_m_res.gap, r_m_res.seen, r_m_res.held});
    assign o_m_axis_tuser  = r_m_res.event_kind;

endmodule

`default_nettype wire

FILE: bench/per_key_gap_severity_tracker_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the per-key gap severity tracker.
// Holds its own per-key severity predictor, a queue-fed stream driver and a result monitor.
// Depends on pkgst_pkg and per_key_gap_severity_tracker.

module per_key_gap_severity_tracker_test;
    import pkgst_pkg::*;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // One input item as the driver presents it.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              present;
        logic [TIME_W-1:0] prev;
        logic [TIME_W-1:0] now;
    } t_arrival;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr = CFG_WARN;
    logic [CFG_DAT_W-1:0]   cfg_wdata = '0;

    per_key_gap_severity_tracker DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: a mirror of the registers and of the per-key tables.
    t_cfg                cfg_now;
    logic [SEV_W-1:0]    key_severity   [KEY_COUNT];
    logic [STREAK_W-1:0] key_streak     [KEY_COUNT];
    logic [TIME_W-1:0]   key_changed_at [KEY_COUNT];

    // Stimulus state: the last arrival time handed out for each key, so that
    // well-formed items carry a previous time that matches the key's history.
    logic [TIME_W-1:0]   key_last_arrival [KEY_COUNT];

    t_arrival arrivals_to_send [$];
    t_result  expected_reports [$];
    int unsigned items_queued = 0;
    int unsigned results_seen = 0;
    int unsigned error_count  = 0;

    // Handshake bookkeeping for the driver, the receiver pacing and the monitor.
    // s_taken is written at the rising edge and read at the falling edge.
    bit          s_taken = 1'b0;
    bit          idling_on = 1'b1;
    int unsigned send_hold = 0, send_quiet = 0;
    int unsigned recv_hold = 0, recv_quiet = 0;

    // Works out the result of one accepted item and updates the key's state,
    // following the block's rules: ignore, recover, escalate, downgrade.
    function automatic t_result track_gap_severity(input t_arrival a);
        t_result           r;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] elapsed;
        logic [SEV_W-1:0]  seen;
        logic [SEV_W-1:0]  held;
        logic              cooled;
        logic              in_range;
        in_range = int'(a.key) < KEY_COUNT;
        r.event_kind = EV_IGNORED;
        r.seen = SEV_NONE;
        r.gap = '0;
        r.held = in_range ? key_severity[a.key] : SEV_NONE;
        if (!a.present || a.prev == '0 || !in_range) begin
            return r;
        end

        gap = (a.now > a.prev) ? a.now - a.prev : '0;
        // Critical is tested first, then alert, then warn, even when the
        // thresholds are written out of order.
        if (gap >= TIME_W'(cfg_now.critical)) begin
            seen = SEV_CRITICAL;
        end else if (gap >= TIME_W'(cfg_now.alert)) begin
            seen = SEV_ALERT;
        end else if (gap >= TIME_W'(cfg_now.warn)) begin
            seen = SEV_WARN;
        end else begin
            seen = SEV_NONE;
        end
        held = key_severity[a.key];
        // Elapsed time wraps modulo 2^64.
        elapsed = a.now - key_changed_at[a.key];
        cooled = elapsed >= TIME_W'(cfg_now.cooldown);
        r.event_kind = EV_UNCHANGED;

        if (seen == SEV_NONE) begin
            // Recovery is immediate and leaves the change time alone.
            if (held != SEV_NONE) begin
                held = SEV_NONE;
                r.event_kind = EV_RECOVERED;
            end
            key_streak[a.key] = '0;
        end else if (seen > held) begin
            // A blocked escalation still clears the streak.
            if (cooled) begin
                held = seen;
                key_changed_at[a.key] = a.now;
                r.event_kind = EV_ESCALATED;
            end
            key_streak[a.key] = '0;
        end else begin
            if (key_streak[a.key] < STREAK_MAX) begin
                key_streak[a.key] = key_streak[a.key] + 1'b1;
            end
            if (seen < held && key_streak[a.key] >= cfg_now.streak_needed && cooled) begin
                held = seen;
                key_changed_at[a.key] = a.now;
                key_streak[a.key] = '0;
                r.event_kind = EV_DOWNGRADED;
            end
        end
        key_severity[a.key] = held;

        r.held = held;
        r.seen = seen;
        r.gap = gap;
        return r;
    endfunction

    // Driver: presents the next queued item at the falling edge once the
    // previous one has been taken, with random gaps while idling is on.
    always @(negedge i_clk) begin : feed_items
        t_arrival a;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (idling_on && send_hold == 0 && send_quiet == 0) begin
                case ($urandom_range(0, 9))
                    0, 1: send_hold = $urandom_range(1, 8);
                    2: send_quiet = $urandom_range(10, 40);
                    default: ;
                endcase
            end
            if (send_quiet > 0) begin
                send_quiet--;
            end
            if (idling_on && send_hold > 0) begin
                send_hold--;
                s_tvalid <= 1'b0;
            end else if (arrivals_to_send.size() > 0) begin
                a = arrivals_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {a.now, a.prev, a.key};
                s_tuser <= a.present;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, in random bursts of stalls while idling is on.
    always @(negedge i_clk) begin : pace_results
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (idling_on && recv_hold == 0 && recv_quiet == 0) begin
                case ($urandom_range(0, 9))
                    0, 1: recv_hold = $urandom_range(1, 8);
                    2: recv_quiet = $urandom_range(10, 40);
                    default: ;
                endcase
            end
            if (recv_quiet > 0) begin
                recv_quiet--;
            end
            if (idling_on && recv_hold > 0) begin
                recv_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: at each rising edge, check an accepted result against the
    // oldest expectation, then predict the result of an accepted item.
    always @(posedge i_clk) begin : watch_ports
        t_result  want;
        t_arrival a;
        s_taken = i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_reports.size() == 0) begin
                $error("result with no item waiting: event_kind %0d, tdata %h",
                       m_tuser, m_tdata);
                error_count++;
            end else begin
                want = expected_reports.pop_front();
                if (m_tuser !== want.event_kind) begin
                    $error("event_kind: expected %0d, actual %0d", want.event_kind, m_tuser);
                    error_count++;
                end
                if (m_tdata[1:0] !== want.held) begin
                    $error("held_severity: expected %0d, actual %0d", want.held, m_tdata[1:0]);
                    error_count++;
                end
                if (m_tdata[3:2] !== want.seen) begin
                    $error("seen_severity: expected %0d, actual %0d", want.seen, m_tdata[3:2]);
                    error_count++;
                end
                if (m_tdata[67:4] !== want.gap) begin
                    $error("gap_ms: expected %0d, actual %0d", want.gap, m_tdata[67:4]);
                    error_count++;
                end
            end
        end
        if (s_taken) begin
            a.key = s_tdata[7:0];
            a.present = s_tuser[0];
            a.prev = s_tdata[71:8];
            a.now = s_tdata[135:72];
            expected_reports.push_back(track_gap_severity(a));
        end
    end

    function automatic void queue_item(input logic [KEY_W-1:0] key, input logic present,
                                       input logic [TIME_W-1:0] prev,
                                       input logic [TIME_W-1:0] now);
        t_arrival a;
        a.key = key;
        a.present = present;
        a.prev = prev;
        a.now = now;
        arrivals_to_send.push_back(a);
        items_queued++;
    endfunction

    // Gap drawn around one of the thresholds: just below, at or above it, anywhere below it, zero, or random.
    function automatic logic [TIME_W-1:0] draw_gap();
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] g;
        case ($urandom_range(0, 2))
            0: t = TIME_W'(cfg_now.warn);
            1: t = TIME_W'(cfg_now.alert);
            default: t = TIME_W'(cfg_now.critical);
        endcase
        case ($urandom_range(0, 5))
            0: g = (t == '0) ? '0 : t - 1;
            1: g = t;
            2: g = t + $urandom_range(1, 50);
            3: g = TIME_W'($urandom_range(0, t[31:0]));
            4: g = '0;
            default: g = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        return g;
    endfunction

    // Pushes a steady run of items on one key with a fixed gap. The first
    // item may jump ahead in time so that the cooldown has passed.
    function automatic void queue_steady_run(input logic [KEY_W-1:0] key,
                                             input logic [TIME_W-1:0] gap,
                                             input int n, input logic [TIME_W-1:0] jump);
        logic [TIME_W-1:0] prev;
        prev = key_last_arrival[key] + jump + 1;
        for (int i = 0; i < n; i++) begin
            queue_item(key, 1'b1, prev, prev + gap);
            prev = prev + gap;
        end
        key_last_arrival[key] = prev;
    endfunction

    // Random items until n of them are ones the block acts on. Most follow a
    // key's own history; the rest are noise with every field random.
    function automatic void queue_random(input int n, input int span);
        logic [KEY_W-1:0]  key;
        logic              present;
        logic [TIME_W-1:0] prev;
        logic [TIME_W-1:0] now;
        int                counted;
        counted = 0;
        while (counted < n) begin
            if ($urandom_range(0, 99) < 15) begin
                key = KEY_W'($urandom_range(0, 255));
                present = 1'($urandom_range(0, 1));
                prev = ($urandom_range(0, 3) == 0) ? '0 : {$urandom, $urandom};
                now = {$urandom, $urandom};
            end else begin
                key = ($urandom_range(0, 7) == 0) ? KEY_W'($urandom_range(0, 255))
                                                  : KEY_W'($urandom_range(0, span - 1));
                present = 1'b1;
                prev = key_last_arrival[key];
                if (prev == '0) begin
                    prev = {$urandom_range(0, 255), $urandom} + 1;
                end
                // Quiet stretches let the cooldown run out without a large gap.
                if ($urandom_range(0, 4) == 0) begin
                    prev = prev + $urandom_range(0, cfg_now.cooldown);
                end
                if ($urandom_range(0, 19) == 0) begin
                    now = prev - $urandom_range(0, 100);
                    key_last_arrival[key] = prev;
                end else begin
                    now = prev + draw_gap();
                    key_last_arrival[key] = now;
                end
            end
            queue_item(key, present, prev, now);
            if (present && prev != '0) begin
                counted++;
            end
        end
    endfunction

    task automatic wait_all_results();
        do begin
            @(negedge i_clk);
        end while (results_seen != items_queued);
        repeat (4) @(negedge i_clk);
    endtask

    // Writes every register; only called with nothing in flight.
    task automatic load_config(input t_cfg c);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_WARN;
        cfg_wdata <= c.warn;
        @(negedge i_clk);
        cfg_addr <= CFG_ALERT;
        cfg_wdata <= c.alert;
        @(negedge i_clk);
        cfg_addr <= CFG_CRITICAL;
        cfg_wdata <= c.critical;
        @(negedge i_clk);
        cfg_addr <= CFG_COOLDOWN;
        cfg_wdata <= c.cooldown;
        @(negedge i_clk);
        cfg_addr <= CFG_STREAK;
        cfg_wdata <= CFG_DAT_W'(c.streak_needed);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cfg_now = c;
        @(posedge i_clk);
    endtask

    initial begin : run_test
        t_cfg c;
        logic [THR_W-1:0] w;
        cfg_now = '{warn: WARN_RST, alert: ALERT_RST, critical: CRITICAL_RST,
                    cooldown: COOLDOWN_RST, streak_needed: STREAK_RST};
        for (int k = 0; k < KEY_COUNT; k++) begin
            key_severity[k] = SEV_NONE;
            key_streak[k] = '0;
            key_changed_at[k] = '0;
            key_last_arrival[k] = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset thresholds (100, 500, 2000, cooldown
        // 5000, streak 3).
        queue_item(8'hFF, 1'b0, TIME_MAX, TIME_MAX);   // key absent
        queue_item(8'h01, 1'b1, '0, 64'd123);          // no previous arrival
        queue_item(8'h01, 1'b1, 64'd1000, 64'd1050);   // below warn, stays none
        queue_item(8'h01, 1'b1, 64'd1050, 64'd1150);   // warn, blocked by cooldown
        queue_item(8'h01, 1'b1, 64'd6000, 64'd8000);   // critical, escalates
        queue_item(8'h01, 1'b1, 64'd8000, 64'd8499);   // just under alert
        queue_item(8'h01, 1'b1, 64'd8499, 64'd8999);   // exactly alert
        queue_item(8'h01, 1'b1, 64'd9000, 64'd10999);  // streak met, not cooled
        queue_item(8'h01, 1'b1, 64'd13000, 64'd13500); // downgrade to alert
        queue_item(8'h01, 1'b1, 64'd13500, 64'd13400); // time went back: recover
        queue_item(8'h01, 1'b1, 64'd13400, 64'd13400); // zero gap while none
        queue_item(8'h02, 1'b1, 64'd1, TIME_MAX);      // largest gap
        queue_item(8'h02, 1'b1, 64'd5, 64'd2005);      // elapsed time wraps
        queue_item(8'h02, 1'b1, 64'd3000, 64'd9000);
        queue_item(8'hFF, 1'b1, 64'd10, 64'd5010);     // highest key escalates
        queue_item(8'hFF, 1'b0, 64'd20, 64'd30);       // ignored, held shows critical
        queue_item(8'hFF, 1'b1, 64'd5010, 64'd5110);
        queue_item(8'hFF, 1'b1, 64'd5110, 64'd5210);
        queue_item(8'hFF, 1'b1, 64'd20000, 64'd20100); // downgrade to warn
        queue_item(8'hFF, 1'b1, 64'd20100, 64'd20150); // recover from warn

        // Tight ordered thresholds with a drain halfway through.
        wait_all_results();
        load_config('{warn: 32'd10, alert: 32'd50, critical: 32'd200,
                      cooldown: 32'd300, streak_needed: 8'd1});
        queue_random(150, 4);
        wait_all_results();
        queue_random(150, 4);

        // All zero: every gap is critical, no cooldown, no streak needed.
        wait_all_results();
        load_config('{warn: '0, alert: '0, critical: '0, cooldown: '0, streak_needed: '0});
        queue_random(200, 4);

        // All registers at their maximum.
        wait_all_results();
        load_config('{warn: '1, alert: '1, critical: '1, cooldown: '1, streak_needed: '1});
        queue_random(250, 4);

        // Thresholds written in reverse order.
        wait_all_results();
        load_config('{warn: 32'd1500, alert: 32'd700, critical: 32'd90,
                      cooldown: 32'd1000, streak_needed: 8'd2});
        queue_random(300, 8);

        // Streak saturation: hold a key at critical long enough for the
        // streak to stop at its maximum, then drop to alert.
        wait_all_results();
        load_config('{warn: 32'd10, alert: 32'd20, critical: 32'd40,
                      cooldown: 32'd100, streak_needed: 8'd255});
        queue_random(120, 2);
        queue_steady_run(8'd200, 64'd40, 1, 64'd1000);
        queue_steady_run(8'd200, 64'd45, 300, '0);
        queue_steady_run(8'd200, 64'd25, 1, 64'd1000);
        queue_random(120, 2);

        // Random ordered thresholds; the last part runs with no idling.
        wait_all_results();
        w = $urandom_range(1, 200);
        c.warn = w;
        c.alert = w + $urandom_range(0, 800);
        c.critical = c.alert + $urandom_range(0, 2000);
        c.cooldown = $urandom_range(0, 3000);
        c.streak_needed = STREAK_W'($urandom_range(0, 6));
        load_config(c);
        queue_random(150, 16);
        wait_all_results();
        idling_on = 1'b0;
        queue_random(150, 16);
        wait_all_results();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin : watchdog
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pkgst_pkg.sv
rtl/pkgst_ram.sv
rtl/pkgst_update.sv
rtl/per_key_gap_severity_tracker.sv
bench/per_key_gap_severity_tracker_test.sv
